@@ rtl/nmg_pkg.sv @@
package nmg_pkg;

  localparam int MAX_MARKERS = 1024;
  localparam int IDX_W       = $clog2(MAX_MARKERS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_W       = 32;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] position;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0] distance;
    logic [1:0]       status;
  } out_rsp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [POS_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/nmg_ram.sv @@
module nmg_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/nmg_ctrl.sv @@
module nmg_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  nmg_pkg::in_req_t          req,
  input  logic [nmg_pkg::POS_W-1:0] line_length,
  input  logic [nmg_pkg::POS_W-1:0] mem_rdata,
  output nmg_pkg::mem_req_t         mem_req,
  output logic                      busy,
  output logic                      rsp_valid,
  output nmg_pkg::out_rsp_t         rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CHK,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_Q_HI,
    S_Q_LO,
    S_FIN
  } state_t;

  state_t                      state_r;
  logic [1:0]                  op_r;
  logic [nmg_pkg::POS_W-1:0]   pos_r;
  logic [nmg_pkg::CNT_W-1:0]   count_r;
  logic [nmg_pkg::CNT_W-1:0]   lo_r;
  logic [nmg_pkg::CNT_W-1:0]   hi_r;
  logic [nmg_pkg::IDX_W-1:0]   mid_r;
  logic [nmg_pkg::IDX_W-1:0]   at_r;
  logic [nmg_pkg::IDX_W-1:0]   j_r;
  logic [nmg_pkg::POS_W-1:0]   lo_v_r;
  logic [nmg_pkg::POS_W-1:0]   hi_v_r;
  logic                        have_lo_r;
  logic                        have_hi_r;
  logic                        rsp_valid_r;
  nmg_pkg::out_rsp_t           rsp_r;

  logic [nmg_pkg::CNT_W:0]     mid_sum;
  logic [nmg_pkg::IDX_W-1:0]   mid;
  logic                        pred;
  logic [nmg_pkg::POS_W-1:0]   gap;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[nmg_pkg::IDX_W:1];

  // Insert searches for the first entry above the position, query for the
  // first entry at or above it.
  assign pred = (op_r == nmg_pkg::OP_INSERT) ? (mem_rdata > pos_r) : (mem_rdata >= pos_r);

  always_comb begin
    if (have_lo_r && have_hi_r) begin
      gap = (hi_v_r - lo_v_r) >> 1;
    end else if (have_lo_r) begin
      gap = (line_length >= lo_v_r) ? (line_length - lo_v_r) : '0;
    end else begin
      gap = (hi_v_r != '0) ? (hi_v_r - 1'b1) : '0;
    end
  end

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = pos_r;
    case (state_r)
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mem_req.raddr = mid;
        end else if (lo_r < count_r) begin
          mem_req.raddr = lo_r[nmg_pkg::IDX_W-1:0];
        end else begin
          mem_req.raddr = lo_r[nmg_pkg::IDX_W-1:0] - 1'b1;
        end
      end
      S_SH_RD: begin
        mem_req.raddr = j_r;
      end
      S_SH_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = j_r + 1'b1;
        mem_req.wdata = mem_rdata;
      end
      S_INS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = at_r;
      end
      S_Q_HI: begin
        mem_req.raddr = at_r - 1'b1;
      end
      default: begin
        mem_req.raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      rsp_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r      <= req.operation;
            pos_r     <= req.position;
            lo_r      <= '0;
            hi_r      <= count_r;
            have_lo_r <= 1'b0;
            have_hi_r <= 1'b0;
            case (req.operation)
              nmg_pkg::OP_CLEAR: begin
                count_r     <= '0;
                rsp_valid_r <= 1'b1;
                rsp_r       <= '{distance: '0, status: nmg_pkg::ST_OK};
              end
              nmg_pkg::OP_INSERT: begin
                if (count_r == nmg_pkg::CNT_W'(nmg_pkg::MAX_MARKERS)) begin
                  rsp_valid_r <= 1'b1;
                  rsp_r       <= '{distance: '0, status: nmg_pkg::ST_FULL};
                end else begin
                  state_r <= S_SRCH;
                end
              end
              nmg_pkg::OP_QUERY: begin
                if (count_r == '0) begin
                  rsp_valid_r <= 1'b1;
                  rsp_r       <= '{distance: '0, status: nmg_pkg::ST_EMPTY};
                end else begin
                  state_r <= S_SRCH;
                end
              end
              default: begin
                rsp_valid_r <= 1'b1;
                rsp_r       <= '{distance: '0, status: nmg_pkg::ST_OK};
              end
            endcase
          end
        end
        S_SRCH: begin
          at_r <= lo_r[nmg_pkg::IDX_W-1:0];
          if (lo_r < hi_r) begin
            mid_r   <= mid;
            state_r <= S_CHK;
          end else if (op_r == nmg_pkg::OP_INSERT) begin
            if (lo_r == count_r) begin
              state_r <= S_INS_WR;
            end else begin
              j_r     <= nmg_pkg::IDX_W'(count_r - 1'b1);
              state_r <= S_SH_RD;
            end
          end else if (lo_r < count_r) begin
            state_r <= S_Q_HI;
          end else begin
            state_r <= S_Q_LO;
          end
        end
        S_CHK: begin
          if (pred) begin
            hi_r <= nmg_pkg::CNT_W'(mid_r);
          end else begin
            lo_r <= nmg_pkg::CNT_W'(mid_r) + 1'b1;
          end
          state_r <= S_SRCH;
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          if (j_r == at_r) begin
            state_r <= S_INS_WR;
          end else begin
            j_r     <= j_r - 1'b1;
            state_r <= S_SH_RD;
          end
        end
        S_INS_WR: begin
          count_r     <= count_r + 1'b1;
          rsp_valid_r <= 1'b1;
          rsp_r       <= '{distance: '0, status: nmg_pkg::ST_OK};
          state_r     <= S_IDLE;
        end
        S_Q_HI: begin
          hi_v_r    <= mem_rdata;
          have_hi_r <= 1'b1;
          // An exact hit is its own lower neighbor; otherwise the entry just
          // below the hit is the largest one under the position.
          if (mem_rdata == pos_r) begin
            lo_v_r    <= mem_rdata;
            have_lo_r <= 1'b1;
            state_r   <= S_FIN;
          end else if (at_r != '0) begin
            state_r <= S_Q_LO;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_Q_LO: begin
          lo_v_r    <= mem_rdata;
          have_lo_r <= 1'b1;
          state_r   <= S_FIN;
        end
        S_FIN: begin
          rsp_valid_r <= 1'b1;
          rsp_r       <= '{distance: gap, status: nmg_pkg::ST_OK};
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;

endmodule

@@ rtl/nearest_marker_gap_query_top.sv @@
// Nearest marker gap query.
// Keeps up to MAX_MARKERS marker positions sorted in one synchronous RAM.
// A request is taken when start is high and busy is low; in_req carries the
// operation (clear, insert, query) and the position. Exactly one response
// follows each request: out_valid is high for one cycle with out_rsp.
// Clear, an unused operation code, an insert into a full store and a query
// on an empty store answer in the cycle after the request.
// Other requests run a binary search over the stored entries, each step a
// RAM read followed by a compare, about log2(count + 1) steps, and one more
// state to close it. An insert then moves every entry from the insertion
// point up one slot, a read and a write per entry, and writes the new marker.
// A query reads one or two neighbors and computes the gap. The single RAM
// port pair serializes all of these steps.
// busy stays high until the response is issued; the receiver cannot stall,
// so a response is never held back. cfg_we writes the line length and must
// only be used while busy is low and no response is pending.
// Reset empties the store at once (the count is cleared; RAM contents are
// not) and sets the line length to all ones.
module nearest_marker_gap_query_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  nmg_pkg::in_req_t          in_req,
  output logic                      out_valid,
  output nmg_pkg::out_rsp_t         out_rsp,
  input  logic                      cfg_we,
  input  logic [nmg_pkg::POS_W-1:0] cfg_wdata
);

  logic [nmg_pkg::POS_W-1:0] line_length_r;
  nmg_pkg::mem_req_t         mem_req;
  logic [nmg_pkg::POS_W-1:0] mem_rdata;
  logic                      accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= '1;
    end else if (cfg_we) begin
      line_length_r <= cfg_wdata;
    end
  end

  assign accept = start && !busy;

  nmg_ram #(
    .DEPTH (nmg_pkg::MAX_MARKERS),
    .WIDTH (nmg_pkg::POS_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  nmg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept),
    .req         (in_req),
    .line_length (line_length_r),
    .mem_rdata   (mem_rdata),
    .mem_req     (mem_req),
    .busy        (busy),
    .rsp_valid   (out_valid),
    .rsp         (out_rsp)
  );

endmodule

@@ rtl/nmg_checker.sv @@
module nmg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input nmg_pkg::in_req_t  in_req,
  input logic              out_valid,
  input nmg_pkg::out_rsp_t out_rsp
);

  // A response is only issued while the block is idle.
  a_rsp_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("response issued while busy");

  // Clear answers in the next cycle with a zero, ok response.
  a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation == nmg_pkg::OP_CLEAR) |=>
      (out_valid && !busy && out_rsp.status == nmg_pkg::ST_OK && out_rsp.distance == '0))
    else $error("clear response wrong or late");

  // Error responses never carry a distance.
  a_err_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != nmg_pkg::ST_OK) |-> (out_rsp.distance == '0))
    else $error("error response with nonzero distance");

  // Any request other than a clear either keeps the block busy or is
  // answered in the next cycle.
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.operation != nmg_pkg::OP_CLEAR) |=> (busy || out_valid))
    else $error("request neither started nor answered");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("activity after reset");

endmodule

bind nearest_marker_gap_query_top nmg_checker u_nmg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
